[hw/rtl/gre_pkg.sv]
// package for the graph reachability engine: sizes, op codes and sequencer states
package gre_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VERTEX_LIMIT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int ROW_COUNT    = VERTEX_LIMIT;
  localparam int ROW_AW       = $clog2(ROW_COUNT);

  localparam int VC_W = 6;
  localparam logic [VC_W-1:0] VC_RESET  = 6'd32;
  localparam logic [VC_W-1:0] LIMIT_N   = VC_W'(VERTEX_LIMIT);

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_REACH  = 2'd1;
  localparam logic [1:0] OP_COMMON = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

endpackage

[hw/rtl/graph_reachability_engine.sv]
// graph reachability engine: adjacency row store, closure sequencer and result emitter
//
// Input channel (in_valid/in_stall) carries op, row_index, row_bits, start_vertex.
// A transfer happens on a rising edge with in_valid high and in_stall low.
// op 0 stores one adjacency row and yields nothing.
// op 1 emits every vertex reachable from start_vertex, ascending; op 2 emits
// every vertex reachable from all vertices in use. Each run ends with last set;
// an empty answer is one result with found low. op 3 is dropped.
// Output channel (out_valid/out_stall) holds each result in a register until
// transferred; the emitter waits while out_stall is high.
// Closure: one adjacency row is read and ORed into the frontier per cycle; a
// reach takes up to n passes (n = vertex_count in use) and a common-target
// query runs n such reach closures. Emission scans one vertex per cycle while
// the output register is free. in_stall stays high from the accepted query
// until its last result is loaded into the output register.
// cfg_data sets vertex_count through cfg_valid/cfg_ready, always ready.
// Synchronous reset clears all rows (no edges), vertex_count to 32, and the
// output register to empty.
module graph_reachability_engine
  import gre_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      op,
  input  logic [4:0]      row_index,
  input  logic [31:0]     row_bits,
  input  logic [4:0]      start_vertex,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [4:0]      vertex,
  output logic            found,
  output logic            last,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [VC_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [VC_W-1:0] vertex_count;
  logic [VC_W-1:0] n;
  logic [31:0]     mask;

  logic [31:0]     rows [ROW_COUNT];
  logic [ROW_COUNT-1:0] row_valid;
  logic [31:0]     row_q;
  logic            write_en;
  logic            rd_en;
  logic [ROW_AW-1:0] rd_addr;

  logic [31:0]     set, set_next, set_upd;
  logic [31:0]     common, common_next;
  logic [31:0]     ans, ans_next, ans_clr;
  logic            common_mode, common_mode_next;
  logic [4:0]      src, src_next;
  logic [VC_W-1:0] idx, idx_next;
  logic            changed, changed_next;
  logic            rd_pend, rd_pend_next;
  logic [4:0]      rd_idx, rd_idx_next;
  logic [4:0]      k, k_next;

  logic            out_valid_next;
  logic [4:0]      vertex_next;
  logic            found_next;
  logic            last_next;
  logic            slot_free;
  logic            in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    if (vertex_count == '0) begin
      n = VC_W'(1);
    end else if (vertex_count > LIMIT_N) begin
      n = LIMIT_N;
    end else begin
      n = vertex_count;
    end
  end

  assign mask     = 32'hFFFF_FFFF >> (6'd32 - n);
  assign write_en = in_xfer && (op == OP_WRITE) && (32'(row_index) < ROW_COUNT);
  assign rd_addr  = idx[ROW_AW-1:0];
  assign ans_clr  = ans & ~(32'b1 << k);

  always_comb begin
    set_upd = set;
    if (rd_pend && set[rd_idx]) begin
      set_upd = set | (row_q & mask);
    end
  end

  always_comb begin
    state_next       = state;
    set_next         = set;
    common_next      = common;
    ans_next         = ans;
    common_mode_next = common_mode;
    src_next         = src;
    idx_next         = idx;
    changed_next     = changed;
    rd_pend_next     = rd_pend;
    rd_idx_next      = rd_idx;
    k_next           = k;
    rd_en            = 1'b0;
    out_valid_next   = out_valid && out_stall;
    vertex_next      = vertex;
    found_next       = found;
    last_next        = last;

    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (op)
            OP_REACH: begin
              common_mode_next = 1'b0;
              if ({1'b0, start_vertex} >= n) begin
                ans_next   = '0;
                k_next     = '0;
                state_next = S_EMIT;
              end else begin
                set_next     = 32'b1 << start_vertex;
                idx_next     = '0;
                changed_next = 1'b0;
                rd_pend_next = 1'b0;
                state_next   = S_SWEEP;
              end
            end
            OP_COMMON: begin
              common_mode_next = 1'b1;
              src_next         = '0;
              set_next         = 32'b1;
              common_next      = mask;
              idx_next         = '0;
              changed_next     = 1'b0;
              rd_pend_next     = 1'b0;
              state_next       = S_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end

      S_SWEEP: begin
        if (set_upd != set) begin
          changed_next = 1'b1;
        end
        if (idx < n) begin
          rd_en        = 1'b1;
          rd_pend_next = 1'b1;
          rd_idx_next  = idx[4:0];
          idx_next     = idx + VC_W'(1);
          set_next     = set_upd;
        end else if (rd_pend) begin
          rd_pend_next = 1'b0;
          set_next     = set_upd;
        end else if (changed) begin
          idx_next     = '0;
          changed_next = 1'b0;
        end else if (!common_mode) begin
          ans_next   = set;
          k_next     = '0;
          state_next = S_EMIT;
        end else begin
          common_next = common & set;
          if ({1'b0, src} == n - VC_W'(1)) begin
            ans_next   = common & set;
            k_next     = '0;
            state_next = S_EMIT;
          end else begin
            src_next     = src + 5'd1;
            set_next     = 32'b1 << (src + 5'd1);
            idx_next     = '0;
            changed_next = 1'b0;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          if (ans == '0) begin
            out_valid_next = 1'b1;
            vertex_next    = '0;
            found_next     = 1'b0;
            last_next      = 1'b1;
            state_next     = S_IDLE;
          end else begin
            if (ans[k]) begin
              out_valid_next = 1'b1;
              vertex_next    = k;
              found_next     = 1'b1;
              last_next      = (ans_clr == '0);
              ans_next       = ans_clr;
              if (ans_clr == '0) begin
                state_next = S_IDLE;
              end
            end
            k_next = k + 5'd1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VC_RESET;
      row_valid    <= '0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      rd_pend   <= rd_pend_next;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (write_en) begin
        row_valid[row_index[ROW_AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      rows[row_index[ROW_AW-1:0]] <= row_bits;
    end
    if (rd_en) begin
      row_q <= row_valid[rd_addr] ? rows[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    set         <= set_next;
    common      <= common_next;
    ans         <= ans_next;
    common_mode <= common_mode_next;
    src         <= src_next;
    idx         <= idx_next;
    changed     <= changed_next;
    rd_idx      <= rd_idx_next;
    k           <= k_next;
    vertex      <= vertex_next;
    found       <= found_next;
    last        <= last_next;
  end

  // an empty answer is always a single result
  assert property (@(posedge clk) disable iff (rst) out_valid && !found |-> last)
    else $error("empty result without last");

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  // pending row reads always address a vertex in use
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) && rd_pend |-> ({1'b0, rd_idx} < n))
    else $error("row read beyond vertex count");

  // the input side is held off while a query is in progress
  assert property (@(posedge clk) disable iff (rst)
    in_xfer && (op == OP_REACH || op == OP_COMMON) |=> in_stall)
    else $error("query accepted without holding off input");

endmodule

[sim/tb.sv]
// testbench for graph_reachability_engine: queued driver, result scoreboard, random graphs
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gre_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 200;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  row;
    logic [31:0] bits;
    logic [4:0]  start;
  } gre_item_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic       found;
    logic       last;
  } answer_t;

  typedef enum int {
    SHAPE_SPARSE,
    SHAPE_DENSE,
    SHAPE_CHAIN,
    SHAPE_RING,
    SHAPE_FULL_OR_EMPTY
  } graph_shape_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      op = OP_WRITE;
  logic [4:0]      row_index = '0;
  logic [31:0]     row_bits = '0;
  logic [4:0]      start_vertex = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [4:0]      vertex;
  logic            found;
  logic            last;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [VC_W-1:0] cfg_data = '0;

  gre_item_t   pending_items[$];
  gre_item_t   current_item;
  answer_t     expected_answers[$];
  answer_t     want;
  logic [31:0] adj_rows [ROW_COUNT];
  logic [VC_W-1:0] vc_shadow = VC_RESET;

  int queued_items = 0;
  int accepted_items = 0;
  int useful_items = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit quiet_tail = 1'b0;

  graph_reachability_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .start_vertex (start_vertex),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex       (vertex),
    .found        (found),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int active_count(logic [VC_W-1:0] vc);
    if (vc == 0) return 1;
    if (int'(vc) > VERTEX_LIMIT) return VERTEX_LIMIT;
    return int'(vc);
  endfunction

  function automatic logic [31:0] active_mask(int n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function automatic logic [31:0] reach_closure(int src, int n);
    logic [31:0] reach;
    logic [31:0] prior;
    int i;
    reach = 32'd1 << src;
    do begin
      prior = reach;
      for (i = 0; i < n; i++)
        if (reach[i]) reach |= adj_rows[i];
      reach &= active_mask(n);
    end while (reach != prior);
    return reach;
  endfunction

  function automatic void predict_answer(gre_item_t it);
    int n;
    int i;
    logic [31:0] answer;
    answer_t a;
    n = active_count(vc_shadow);
    case (it.op)
      OP_WRITE: begin
        if (int'(it.row) < ROW_COUNT) adj_rows[it.row] = it.bits;
        return;
      end
      OP_REACH: begin
        answer = (int'(it.start) >= n) ? 32'd0 : reach_closure(int'(it.start), n);
      end
      OP_COMMON: begin
        answer = active_mask(n);
        for (i = 0; i < n; i++) answer &= reach_closure(i, n);
      end
      default: return;
    endcase
    if (answer == 32'd0) begin
      a.vertex = '0;
      a.found = 1'b0;
      a.last = 1'b1;
      expected_answers.push_back(a);
    end else begin
      for (i = 0; i < 32; i++) begin
        if (answer[i]) begin
          a.vertex = 5'(i);
          a.found = 1'b1;
          a.last = ((answer >> i) == 32'd1);
          expected_answers.push_back(a);
        end
      end
    end
  endfunction

  function automatic logic [31:0] row_pattern(graph_shape_t shape, int i, int n);
    logic [31:0] junk;
    junk = $urandom & ~active_mask(n);
    case (shape)
      SHAPE_SPARSE: return ($urandom & $urandom & $urandom) | junk;
      SHAPE_DENSE:  return $urandom | $urandom;
      SHAPE_CHAIN:  return ((i + 1 < 32) ? (32'd1 << (i + 1)) : 32'd0) | junk;
      SHAPE_RING:   return ((i == 0) ? (32'd1 << (n - 1)) : (32'd1 << (i - 1))) | junk;
      default:      return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
      vc_shadow = VC_RESET;
      foreach (adj_rows[i]) adj_rows[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) vc_shadow = cfg_data;
      if (in_valid && !in_stall) begin
        predict_answer(current_item);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !quiet_tail &&
                     $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          current_item = pending_items.pop_front();
          op <= current_item.op;
          row_index <= current_item.row;
          row_bits <= current_item.bits;
          start_vertex <= current_item.start;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transfer: vertex %0d found %0b last %0b",
                     vertex, found, last);
        end else begin
          want = expected_answers.pop_front();
          if (vertex !== want.vertex || found !== want.found || last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result mismatch: expected vertex %0d found %0b last %0b, ",
                        "got vertex %0d found %0b last %0b"},
                       want.vertex, want.found, want.last, vertex, found, last);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(logic [1:0] code, logic [4:0] row, logic [31:0] bits,
                           logic [4:0] start);
    gre_item_t it;
    it.op = code;
    it.row = row;
    it.bits = bits;
    it.start = start;
    pending_items.push_back(it);
    queued_items++;
    if (code != OP_UNUSED) useful_items++;
  endtask

  task automatic write_vertex_count(logic [VC_W-1:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (accepted_items != queued_items || expected_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    int vc;
    int kind;
    int i;
    int directed_items;
    graph_shape_t shape;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty graph, full vertex count
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd0);
    push_item(OP_COMMON, 5'($urandom_range(0, 31)), $urandom, 5'($urandom_range(0, 31)));
    push_item(OP_UNUSED, 5'd31, 32'hFFFF_FFFF, 5'd31);
    push_item(OP_WRITE, 5'd31, 32'hFFFF_FFFF, 5'($urandom_range(0, 31)));
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd31);
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd30);
    push_item(OP_WRITE, 5'd0, 32'h8000_0000, 5'($urandom_range(0, 31)));
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd0);
    drain();

    write_vertex_count(VC_W'(1));
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd0);
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd31);
    push_item(OP_COMMON, 5'($urandom_range(0, 31)), $urandom, 5'($urandom_range(0, 31)));
    push_item(OP_WRITE, 5'd5, 32'h0000_0001, 5'($urandom_range(0, 31)));
    drain();

    write_vertex_count(VC_W'(0));
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd1);
    push_item(OP_COMMON, 5'($urandom_range(0, 31)), $urandom, 5'($urandom_range(0, 31)));
    drain();

    write_vertex_count(VC_W'(6));
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd5);
    push_item(OP_COMMON, 5'($urandom_range(0, 31)), $urandom, 5'($urandom_range(0, 31)));
    drain();

    write_vertex_count(VC_W'(63));
    push_item(OP_WRITE, 5'd1, 32'd0, 5'($urandom_range(0, 31)));
    push_item(OP_COMMON, 5'($urandom_range(0, 31)), $urandom, 5'($urandom_range(0, 31)));
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd5);
    push_item(OP_WRITE, 5'd31, 32'd0, 5'($urandom_range(0, 31)));
    push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom, 5'd0);
    drain();

    directed_items = useful_items;
    while (useful_items < directed_items + RANDOM_ITEMS) begin
      if (useful_items >= directed_items + RANDOM_ITEMS - 30) quiet_tail = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        case ($urandom_range(0, 5))
          0: vc = 0;
          1: vc = 1;
          2: vc = 2;
          3: vc = 32;
          4: vc = 33;
          default: vc = 63;
        endcase
      end else if (kind < 8) begin
        vc = $urandom_range(3, 12);
      end else begin
        vc = $urandom_range(13, 31);
      end
      n = (vc == 0) ? 1 : ((vc > VERTEX_LIMIT) ? VERTEX_LIMIT : vc);
      if (n > 12)
        case ($urandom_range(0, 2))
          0: shape = SHAPE_SPARSE;
          1: shape = SHAPE_DENSE;
          default: shape = SHAPE_FULL_OR_EMPTY;
        endcase
      else
        shape = graph_shape_t'($urandom_range(0, 4));
      write_vertex_count(VC_W'(vc));

      // load a fresh graph most of the time, otherwise reuse what is stored
      if ($urandom_range(0, 4) != 0)
        for (i = 0; i < n; i++)
          push_item(OP_WRITE, 5'(i), row_pattern(shape, i, n), 5'($urandom_range(0, 31)));
      repeat ($urandom_range(0, 1))
        push_item(OP_UNUSED, 5'($urandom_range(0, 31)), $urandom,
                  5'($urandom_range(0, 31)));
      if (n < 32 && $urandom_range(0, 2) == 0)
        push_item(OP_WRITE, 5'($urandom_range(n, 31)), $urandom, 5'($urandom_range(0, 31)));

      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 9);
        if (kind < 5)
          push_item(OP_REACH, 5'($urandom_range(0, 31)), $urandom,
                    5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) :
                                                     $urandom_range(0, n - 1)));
        else if (kind < 8)
          push_item(OP_COMMON, 5'($urandom_range(0, 31)), $urandom,
                    5'($urandom_range(0, 31)));
        else if (kind == 8)
          push_item(OP_WRITE, 5'($urandom_range(0, 31)), $urandom,
                    5'($urandom_range(0, 31)));
        else
          push_item(OP_UNUSED, 5'($urandom_range(0, 31)), $urandom,
                    5'($urandom_range(0, 31)));
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/gre_pkg.sv
hw/rtl/graph_reachability_engine.sv
sim/tb.sv
